@@ rtl/pal_pkg.sv @@
// Package for the positional array list block.
// Request/result structs, operation and status codes, controller types.
// No dependencies.
package pal_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int POS_W        = 13;
  localparam int VAL_W        = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                    mode;
    logic [POS_W-1:0]         position;
    logic signed [VAL_W-1:0]  value;
  } request_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  data;
    logic [POS_W-1:0]         count;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the request
    logic check;    // latch status, set up read pointer
    logic fetch;    // read the addressed element for capture
    logic shift;    // read one element to be moved
    logic put;      // write the inserted value
    logic respond;  // update count, present result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  err;     // request fails its range or full check
    logic  append;  // insert at the tail, nothing to move
    logic  last;    // read pointer is at the final element of the sweep
  } dp_stat_t;

endpackage

@@ rtl/pal_ctrl.sv @@
// Controller state machine for the positional array list.
// Sequences checks, element sweeps and the response. Uses pal_pkg.
module pal_ctrl
  import pal_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.err || stat.mode == MODE_CLEAR) begin
          state_next = S_RESP;
        end else if (stat.mode == MODE_INSERT) begin
          state_next = stat.append ? S_PUT : S_SHIFT;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.mode == MODE_DELETE && !stat.last) state_next = S_SHIFT;
        else state_next = S_DRAIN;
      end
      S_SHIFT: begin
        if (stat.last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = (stat.mode == MODE_INSERT) ? S_PUT : S_RESP;
      end
      S_PUT:  state_next = S_RESP;
      S_RESP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != S_IDLE);
    cmd         = '0;
    cmd.load    = (state == S_IDLE) && start;
    cmd.check   = (state == S_CHECK);
    cmd.fetch   = (state == S_FETCH);
    cmd.shift   = (state == S_SHIFT);
    cmd.put     = (state == S_PUT);
    cmd.respond = (state == S_RESP);
  end

endmodule

@@ rtl/pal_dp.sv @@
// Datapath for the positional array list: element memory, count, read
// pointer, one-deep move pipeline and result register. Uses pal_pkg.
module pal_dp
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output logic     done,
  output result_t  result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  request_t               req_r;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  status_t                st;
  status_t                st_next;
  logic signed [31:0]     dat;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          pend_addr;
  logic                   pend_wr;
  logic                   pend_cap;
  logic signed [31:0]     mem [CAPACITY];
  logic signed [31:0]     rdata;

  logic [POS_W:0]         pos_ext;
  logic [POS_W:0]         cnt_ext;
  logic [AW-1:0]          p0;
  logic [AW-1:0]          cnt_m1;
  logic                   is_ins;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic signed [31:0]     mem_wdata;

  assign is_ins  = (req_r.mode == MODE_INSERT);
  assign pos_ext = {1'b0, req_r.position};
  assign cnt_ext = (POS_W + 1)'(count);
  assign p0      = AW'(req_r.position - POS_W'(1));
  assign cnt_m1  = AW'(count - CW'(1));

  always_comb begin
    st_next = ST_DONE;
    case (req_r.mode)
      MODE_INSERT: begin
        if (req_r.position == '0 || pos_ext > cnt_ext + (POS_W + 1)'(1)) begin
          st_next = ST_RANGE;
        end else if (cnt_ext == (POS_W + 1)'(CAPACITY)) begin
          st_next = ST_FULL;
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (req_r.position == '0 || pos_ext > cnt_ext) st_next = ST_RANGE;
      end
      default: st_next = ST_DONE;
    endcase
  end

  always_comb begin
    stat.mode   = req_r.mode;
    stat.err    = (st_next != ST_DONE);
    stat.append = (pos_ext == cnt_ext + (POS_W + 1)'(1));
    stat.last   = is_ins ? (rd_addr == p0) : (rd_addr == cnt_m1);
  end

  always_comb begin
    count_next = count;
    if (st == ST_DONE) begin
      case (req_r.mode)
        MODE_INSERT: count_next = count + CW'(1);
        MODE_DELETE: count_next = count - CW'(1);
        MODE_CLEAR:  count_next = '0;
        default:     count_next = count;
      endcase
    end
  end

  // single write port: a pending move, or the inserted value
  assign mem_we    = pend_wr || cmd.put;
  assign mem_waddr = cmd.put ? p0 : pend_addr;
  assign mem_wdata = cmd.put ? req_r.value : rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pend_wr  <= 1'b0;
      pend_cap <= 1'b0;
      done     <= 1'b0;
    end else begin
      pend_wr  <= cmd.shift;
      pend_cap <= cmd.fetch;
      done     <= cmd.respond;
      if (cmd.respond) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= request;
    if (cmd.check) begin
      st      <= st_next;
      dat     <= '0;
      rd_addr <= is_ins ? cnt_m1 : p0;
    end
    // insert sweeps downward moving each element up; delete sweeps upward
    if (cmd.fetch || cmd.shift) begin
      rd_addr   <= is_ins ? rd_addr - AW'(1) : rd_addr + AW'(1);
      pend_addr <= is_ins ? rd_addr + AW'(1) : rd_addr - AW'(1);
    end
    if (pend_cap) dat <= rdata;
    if (cmd.respond) begin
      result.status <= st;
      result.data   <= dat;
      result.count  <= POS_W'(count_next);
    end
  end

endmodule

@@ rtl/positional_array_list.sv @@
// Ordered list of signed 32-bit values in a CAPACITY-entry memory: insert,
// delete, clear and read at 1-based positions. A request is taken when start
// is high and busy is low; its result is on result with done high for exactly
// one cycle, and the receiver cannot stall it. Insert and delete move the
// elements behind the position one per cycle through the memory's single read
// and write port; an insert at the tail moves nothing. The next request can be
// taken in the cycle that done is high. No clearing pass after reset.
// Depends on pal_pkg, pal_ctrl, pal_dp.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  pal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.check, cmd.fetch, cmd.shift, cmd.put, cmd.respond}))
    else $error("more than one datapath command at once");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.respond))
    else $error("result strobe without a response cycle");

  a_err_data: assert property (@(posedge clk) disable iff (rst)
    done && result.status != ST_DONE |-> result.data == '0)
    else $error("rejected request returned nonzero data");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    done |-> result.count <= POS_W'(CAPACITY))
    else $error("count beyond capacity");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for positional_array_list: directed and random insert, delete, clear and
// read requests, checked against a queue-based model of the list. Depends on pal_pkg.
module tb
  import pal_pkg::*;
();

  localparam int CAP      = CAPACITY_DEF;
  localparam int MAX_POS  = (1 << POS_W) - 1;
  localparam int LIMIT    = 2_000_000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  logic signed [VAL_W-1:0] list_model[$];
  result_t                 pending_results[$];
  int                      errors = 0;
  int                      cycles = 0;
  int                      burst_left;

  positional_array_list #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Applies one request to the list model and returns the result it should produce.
  function automatic result_t apply_to_list(request_t req);
    result_t res;
    int      pos;
    int      n;
    pos        = int'(req.position);
    n          = list_model.size();
    res.status = ST_DONE;
    res.data   = '0;
    case (req.mode)
      MODE_INSERT: begin
        // range check wins over the full check
        if (pos < 1 || pos > n + 1) res.status = ST_RANGE;
        else if (n >= CAP) res.status = ST_FULL;
        else list_model.insert(pos - 1, req.value);
      end
      MODE_DELETE: begin
        if (pos < 1 || pos > n) begin
          res.status = ST_RANGE;
        end else begin
          res.data = list_model[pos - 1];
          list_model.delete(pos - 1);
        end
      end
      MODE_CLEAR: list_model.delete();
      default: begin
        if (pos < 1 || pos > n) res.status = ST_RANGE;
        else res.data = list_model[pos - 1];
      end
    endcase
    res.count = POS_W'(list_model.size());
    return res;
  endfunction

  function automatic request_t make_request(mode_t m, int pos, logic [VAL_W-1:0] val);
    request_t req;
    req.mode     = m;
    req.position = POS_W'(pos);
    req.value    = val;
    return req;
  endfunction

  // Mostly in-range positions; about one request in ten takes any 13-bit position.
  function automatic request_t random_request(int ins_pct, int del_pct, int clr_pct);
    request_t req;
    int       r;
    int       n;
    n = list_model.size();
    r = $urandom_range(0, 99);
    if (r < ins_pct) req.mode = MODE_INSERT;
    else if (r < ins_pct + del_pct) req.mode = MODE_DELETE;
    else if (r < ins_pct + del_pct + clr_pct) req.mode = MODE_CLEAR;
    else req.mode = MODE_READ;
    if ($urandom_range(0, 9) == 0) req.position = POS_W'($urandom_range(0, MAX_POS));
    else if (req.mode == MODE_INSERT) req.position = POS_W'($urandom_range(1, n + 1));
    else if (n == 0) req.position = POS_W'(1);
    else req.position = POS_W'($urandom_range(1, n));
    req.value = $urandom;
    return req;
  endfunction

  // Sends one request in bursts separated by random gaps; leaves start high on return.
  task automatic send_request(input request_t req);
    int gap;
    int r;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      if (r < 6) gap = $urandom_range(0, 3);
      else if (r < 9) gap = $urandom_range(4, 20);
      else gap = $urandom_range(21, CAP + 12);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_to_list(req));
  endtask

  // Holds off until every outstanding result has come back.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t exp;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d data %0d count %0d", $time,
                 result.status, result.data, result.count);
        errors++;
      end else begin
        exp = pending_results.pop_front();
        if (result !== exp) begin
          $display("%0t: mismatch: expected status %0d data %0d count %0d, got %0d %0d %0d",
                   $time, exp.status, exp.data, exp.count,
                   result.status, result.data, result.count);
          errors++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_request(make_request(MODE_READ, 1, 32'h1234_5678));
    send_request(make_request(MODE_DELETE, 1, 32'hFFFF_FFFF));
    send_request(make_request(MODE_INSERT, 0, 32'h1111_1111));
    send_request(make_request(MODE_INSERT, 2, 32'h2222_2222));
    send_request(make_request(MODE_INSERT, 1, 32'h7FFF_FFFF));
    send_request(make_request(MODE_INSERT, 2, 32'h8000_0000));   // tail
    send_request(make_request(MODE_INSERT, 1, 32'hFFFF_FFFF));   // head
    send_request(make_request(MODE_INSERT, 2, 32'h0000_0000));   // middle
    for (int p = 1; p <= 5; p++) send_request(make_request(MODE_READ, p, '0));
    send_request(make_request(MODE_READ, MAX_POS, 32'hFFFF_FFFF));
    send_request(make_request(MODE_DELETE, MAX_POS, '0));
    send_request(make_request(MODE_INSERT, MAX_POS, 32'h5A5A_A5A5));
    send_request(make_request(MODE_DELETE, 2, '0));
    send_request(make_request(MODE_DELETE, 3, '0));
    send_request(make_request(MODE_DELETE, 1, '0));
    send_request(make_request(MODE_CLEAR, MAX_POS, 32'hDEAD_BEEF));
    send_request(make_request(MODE_READ, 1, '0));
    send_request(make_request(MODE_CLEAR, 0, '0));
  endtask

  task automatic test_full_list();
    while (list_model.size() < CAP)
      send_request(make_request(MODE_INSERT, $urandom_range(1, list_model.size() + 1),
                                $urandom));
    send_request(make_request(MODE_INSERT, CAP + 1, $urandom));
    send_request(make_request(MODE_INSERT, CAP + 2, $urandom));
    send_request(make_request(MODE_INSERT, 0, $urandom));
    send_request(make_request(MODE_READ, CAP, '0));
    send_request(make_request(MODE_READ, CAP + 1, '0));
    send_request(make_request(MODE_DELETE, 1, '0));
    send_request(make_request(MODE_INSERT, 1, $urandom));
    send_request(make_request(MODE_DELETE, CAP, '0));
    send_request(make_request(MODE_INSERT, CAP, $urandom));
    wait_idle();
    while (list_model.size() > CAP / 2)
      send_request(make_request(MODE_DELETE, $urandom_range(1, list_model.size()), '0));
  endtask

  task automatic test_random(int n_items, int ins_pct, int del_pct, int clr_pct);
    repeat (n_items) send_request(random_request(ins_pct, del_pct, clr_pct));
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    request    = '0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    wait_idle();
    test_full_list();
    test_random(300, 60, 20, 2);   // grows toward full
    wait_idle();
    test_random(200, 25, 50, 2);   // shrinks toward empty
    test_random(220, 45, 30, 3);

    wait_idle();
    repeat (CAP + 10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
